// ===== hw/rtl/command_history_ring_assert.svh =====
// Assertion macros used by the checker of the history ring.
`ifndef COMMAND_HISTORY_RING_ASSERT_SVH
`define COMMAND_HISTORY_RING_ASSERT_SVH

// same-cycle implication, ignored while reset is held
`define CHR_ASSERT_IMP(NAME, ANT, CON) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |-> (CON)) \
        else $error("history ring check failed");

// next-cycle implication, ignored while reset is held
`define CHR_ASSERT_NXT(NAME, ANT, CON) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |=> (CON)) \
        else $error("history ring check failed");

// next-cycle implication that also runs during reset
`define CHR_ASSERT_RST(NAME, ANT, CON) \
    NAME: assert property (@(posedge i_clk) (ANT) |=> (CON)) \
        else $error("history ring reset check failed");

`endif

// ===== hw/rtl/chr_pkg.sv =====
`default_nettype none

package chr_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int LINE_LENGTH_DEF = 64;

    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PREV  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CHAR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE   = 3'd4;

    localparam logic [CHAR_W-1:0] NO_CHAR = 8'd0;

endpackage

`default_nettype wire

// ===== hw/rtl/command_history_ring.sv =====
// Command line history ring.
// Requests: start with i_cmd/i_character/i_last, taken when start is high and busy
// is low. Add requests stage one byte of a line; the request with i_last set ends
// the line and answers one result (stored, duplicate or empty). Previous and next
// walk a cursor from the newest entry and answer the entry's bytes, one result a
// cycle, the final one with o_end_of_run; with nothing to show one no-entry result.
// Results appear for one cycle under o_strobe; the receiver cannot stall them.
// Flow: an add byte goes straight back to idle, or through S_CMP when it is compared
// against the newest entry. A stored line is copied in S_COPY from the staging
// memory into the entry memory, one byte a cycle. Previous/next pass through
// S_NAV_ADDR and S_NAV_LEN and then S_EMIT, which reads the entry's bytes through
// the single read port of the entry memory. No-entry answers given in idle come
// in the cycle after the request. Reset (synchronous, active low) empties the
// ring, drops the staged line and clears the cursor; the memories are not cleared.
`default_nettype none

module command_history_ring #(
    parameter int ENTRIES     = chr_pkg::ENTRIES_DEF,
    parameter int LINE_LENGTH = chr_pkg::LINE_LENGTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [chr_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [chr_pkg::CHAR_W-1:0]    i_character,
    input  wire logic                          i_last,
    output logic                               o_strobe,
    output logic [chr_pkg::STATUS_W-1:0]       o_status,
    output logic [chr_pkg::CHAR_W-1:0]         o_character_res,
    output logic                               o_end_of_run
);

    localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int COL_W    = $clog2(LINE_LENGTH);
    localparam int ADDR_W   = SLOT_W + COL_W;
    localparam int ST_DEPTH = 2 ** ADDR_W;
    localparam int CW       = chr_pkg::CHAR_W;

    localparam logic [COL_W-1:0]  MAX_COL   = COL_W'(LINE_LENGTH - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CMP      = 7'b0000010,
        S_COMMIT   = 7'b0000100,
        S_COPY     = 7'b0001000,
        S_NAV_ADDR = 7'b0010000,
        S_NAV_LEN  = 7'b0100000,
        S_EMIT     = 7'b1000000
    } t_state;

    // memories
    logic [CW-1:0]    stg_mem [LINE_LENGTH];
    logic [CW-1:0]    ent_mem [ST_DEPTH];
    logic [COL_W-1:0] len_mem [ENTRIES];

    logic [CW-1:0]    r_stg_rdata;
    logic [CW-1:0]    r_ent_rdata;
    logic [COL_W-1:0] r_len_rdata;

    logic              stg_we;
    logic [COL_W-1:0]  stg_waddr;
    logic [COL_W-1:0]  stg_raddr;
    logic              ent_we;
    logic [ADDR_W-1:0] ent_waddr;
    logic [ADDR_W-1:0] ent_raddr;
    logic              len_we;

    // control and datapath registers
    t_state r_state, n_state;
    logic [COL_W-1:0]  r_slen, n_slen;
    logic              r_ov, n_ov;
    logic              r_match, n_match;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [SLOT_W-1:0] r_newest, n_newest;
    logic [COL_W-1:0]  r_newest_len, n_newest_len;
    logic              r_cur_v, n_cur_v;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [CW-1:0]     r_ch, n_ch;
    logic              r_last, n_last;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [COL_W-1:0]  r_len, n_len;
    logic [COL_W-1:0]  r_idx, n_idx;
    logic              r_pv, n_pv;
    logic [COL_W-1:0]  r_pidx, n_pidx;
    logic              r_strobe, n_strobe;
    logic [chr_pkg::STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]     r_char, n_char;
    logic              r_end, n_end;

    logic              accept;
    logic              full;
    logic [CNT_W-1:0]  cur_ext;
    logic [SLOT_W:0]   cur_slot_wide;
    logic [SLOT_W-1:0] cur_slot;
    logic [SLOT_W-1:0] next_slot;
    logic [SLOT_W-1:0] newest_inc;
    logic [SLOT_W-1:0] oldest_inc;
    logic              issue_more;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_count == FULL_CNT);
    assign cur_ext  = CNT_W'(r_cur);

    // slot of the cursor entry: newest minus cursor, modulo the ring size
    assign cur_slot_wide = (r_cur <= r_newest)
                         ? ({1'b0, r_newest} - {1'b0, r_cur})
                         : ({1'b0, r_newest} + (SLOT_W + 1)'(ENTRIES) - {1'b0, r_cur});
    assign cur_slot      = cur_slot_wide[SLOT_W-1:0];

    assign newest_inc = (r_newest == LAST_SLOT) ? '0 : r_newest + 1'b1;
    assign oldest_inc = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
    assign next_slot  = (r_count == '0) ? r_oldest : newest_inc;
    assign issue_more = (r_idx != r_len);

    always_comb begin
        n_state      = r_state;
        n_slen       = r_slen;
        n_ov         = r_ov;
        n_match      = r_match;
        n_count      = r_count;
        n_oldest     = r_oldest;
        n_newest     = r_newest;
        n_newest_len = r_newest_len;
        n_cur_v      = r_cur_v;
        n_cur        = r_cur;
        n_ch         = r_ch;
        n_last       = r_last;
        n_slot       = r_slot;
        n_len        = r_len;
        n_idx        = r_idx;
        n_pv         = 1'b0;
        n_pidx       = r_pidx;
        n_strobe     = 1'b0;
        n_status     = r_status;
        n_char       = chr_pkg::NO_CHAR;
        n_end        = 1'b1;

        stg_we    = 1'b0;
        stg_waddr = r_slen;
        stg_raddr = r_idx;
        ent_we    = 1'b0;
        ent_waddr = {r_slot, r_pidx};
        ent_raddr = {r_slot, r_idx};
        len_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        chr_pkg::CMD_ADD: begin
                            n_cur_v = 1'b0;
                            n_ch    = i_character;
                            n_last  = i_last;
                            n_state = i_last ? S_COMMIT : S_IDLE;
                            if (i_character != chr_pkg::NO_CHAR) begin
                                if (r_slen < MAX_COL) begin
                                    stg_we = 1'b1;
                                    n_slen = r_slen + 1'b1;
                                    if (r_count != '0) begin
                                        if (r_slen >= r_newest_len) begin
                                            n_match = 1'b0;
                                        end else begin
                                            // compare against the newest entry's byte
                                            ent_raddr = {r_newest, r_slen};
                                            n_state   = S_CMP;
                                        end
                                    end
                                end else begin
                                    n_ov = 1'b1;
                                end
                            end
                        end
                        chr_pkg::CMD_PREV: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = chr_pkg::ST_NONE;
                            end else begin
                                n_cur_v = 1'b1;
                                n_state = S_NAV_ADDR;
                                if (!r_cur_v) begin
                                    n_cur = '0;
                                end else if ((cur_ext + CNT_W'(1)) < r_count) begin
                                    n_cur = r_cur + 1'b1;
                                end
                            end
                        end
                        chr_pkg::CMD_NEXT: begin
                            if (r_count == '0 || !r_cur_v) begin
                                n_strobe = 1'b1;
                                n_status = chr_pkg::ST_NONE;
                            end else if (r_cur != '0) begin
                                n_cur   = r_cur - 1'b1;
                                n_state = S_NAV_ADDR;
                            end else begin
                                n_cur_v  = 1'b0;
                                n_strobe = 1'b1;
                                n_status = chr_pkg::ST_NONE;
                            end
                        end
                        chr_pkg::CMD_RESET: begin
                            n_cur_v = 1'b0;
                        end
                        chr_pkg::CMD_CLEAR: begin
                            n_count  = '0;
                            n_oldest = '0;
                            n_cur_v  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (r_ent_rdata != r_ch) begin
                    n_match = 1'b0;
                end
                n_state = r_last ? S_COMMIT : S_IDLE;
            end
            S_COMMIT: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_slen == '0 && !r_ov) begin
                    n_status = chr_pkg::ST_EMPTY;
                end else if (r_count != '0 && !r_ov && r_match && r_newest_len == r_slen) begin
                    n_status = chr_pkg::ST_DUP;
                end else begin
                    n_status     = chr_pkg::ST_STORED;
                    len_we       = 1'b1;
                    n_slot       = next_slot;
                    n_newest     = next_slot;
                    n_newest_len = r_slen;
                    n_len        = r_slen;
                    n_idx        = '0;
                    n_state      = S_COPY;
                    if (full) begin
                        n_oldest = oldest_inc;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                n_slen  = '0;
                n_ov    = 1'b0;
                n_match = 1'b1;
            end
            S_COPY: begin
                // read staging at r_idx, write the entry in the next cycle
                if (issue_more) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pv) begin
                    ent_we = 1'b1;
                    if (r_pidx == r_len - 1'b1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NAV_ADDR: begin
                n_slot  = cur_slot;
                n_state = S_NAV_LEN;
            end
            S_NAV_LEN: begin
                if (r_len_rdata == '0) begin
                    n_strobe = 1'b1;
                    n_status = chr_pkg::ST_NONE;
                    n_state  = S_IDLE;
                end else begin
                    n_len   = r_len_rdata;
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (issue_more) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pv) begin
                    n_strobe = 1'b1;
                    n_status = chr_pkg::ST_CHAR;
                    n_char   = r_ent_rdata;
                    n_end    = (r_pidx == r_len - 1'b1);
                    if (n_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            stg_mem[stg_waddr] <= i_character;
        end
        r_stg_rdata <= stg_mem[stg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= r_stg_rdata;
        end
        r_ent_rdata <= ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            len_mem[next_slot] <= r_slen;
        end
        r_len_rdata <= len_mem[cur_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slen   <= '0;
            r_ov     <= 1'b0;
            r_match  <= 1'b1;
            r_count  <= '0;
            r_oldest <= '0;
            r_cur_v  <= 1'b0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slen   <= n_slen;
            r_ov     <= n_ov;
            r_match  <= n_match;
            r_count  <= n_count;
            r_oldest <= n_oldest;
            r_cur_v  <= n_cur_v;
            r_pv     <= n_pv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_newest     <= n_newest;
        r_newest_len <= n_newest_len;
        r_cur        <= n_cur;
        r_ch         <= n_ch;
        r_last       <= n_last;
        r_slot       <= n_slot;
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_status     <= n_status;
        r_char       <= n_char;
        r_end        <= n_end;
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_character_res = r_char;
    assign o_end_of_run    = r_end;

endmodule

`default_nettype wire

// ===== hw/rtl/chr_checker.sv =====
`default_nettype none

`include "command_history_ring_assert.svh"

module chr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            o_strobe,
    input wire logic [chr_pkg::STATUS_W-1:0]    o_status,
    input wire logic [chr_pkg::CHAR_W-1:0]      o_character_res,
    input wire logic                            o_end_of_run
);

    logic status_only;
    logic no_byte;
    logic more_bytes;
    logic byte_res;

    assign status_only = o_strobe && (o_status != chr_pkg::ST_CHAR);
    assign no_byte     = o_end_of_run && (o_character_res == chr_pkg::NO_CHAR);
    assign more_bytes  = o_strobe && !o_end_of_run;
    assign byte_res    = o_strobe && (o_status == chr_pkg::ST_CHAR);

    // a result only follows a request being taken or in progress
    `CHR_ASSERT_IMP(a_res_after_req, o_strobe, $past(start) || $past(busy))

    // status-only results are single and carry no byte
    `CHR_ASSERT_IMP(a_status_single, status_only, no_byte)

    // entry bytes stream without gaps until the final one
    `CHR_ASSERT_NXT(a_stream_gapless, more_bytes, byte_res)

    `CHR_ASSERT_RST(a_reset_idle, !i_rst_n, !busy && !o_strobe)

endmodule

bind command_history_ring chr_checker u_chr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_character_res (o_character_res),
    .o_end_of_run    (o_end_of_run)
);

`default_nettype wire
